// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define AP_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define AP_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Property that must hold at every clock edge outside reset.
`define AP_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`endif

// ===== rtl/slr_pkg.sv =====
// Shared types and constants for the scheduled linear ramp core.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package slr_pkg;

  localparam int NUM_SEG   = 8;
  localparam int SEG_IDX_W = (NUM_SEG > 1) ? $clog2(NUM_SEG) : 1;
  localparam int TIME_W    = 32;
  localparam int VAL_W     = 24;
  localparam int FRAC_W    = 16;
  localparam int DIV_CNT_W = $clog2(FRAC_W);
  localparam int REQ_W     = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_START_CUR = 2'd0,
    REQ_START_VAL = 2'd1,
    REQ_SET_FLAT  = 2'd2,
    REQ_QUERY     = 2'd3
  } req_t;

  // controller -> datapath
  typedef struct packed {
    logic                 load_in;
    logic                 scan_step;
    logic [SEG_IDX_W-1:0] idx;
    logic                 load_sel;
    logic                 check;
    logic                 div_init;
    logic                 div_step;
    logic                 mul;
    logic                 fin;
    logic                 write_seg;
    logic                 set_flat;
    logic                 push_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t in_req;
    req_t req;
    logic early;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/slr_ctrl.sv =====
// Sequencer for the scheduled linear ramp: scan, select, check, divide, multiply, then write back or output.
// Depends on slr_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module slr_ctrl import slr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_LOAD, ST_CHECK, ST_BRANCH,
    ST_DIV, ST_MUL, ST_FIN, ST_DONE, ST_WRITE, ST_FLAT
  } state_t;

  state_t               state_r, state_nxt;
  logic [SEG_IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  localparam logic [SEG_IDX_W-1:0] LAST_IDX = SEG_IDX_W'(NUM_SEG - 1);
  localparam logic [DIV_CNT_W-1:0] LAST_DIV = DIV_CNT_W'(FRAC_W - 1);

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    div_cnt_nxt  = div_cnt_r;
    cmd          = '0;
    cmd.idx      = scan_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in  = 1'b1;
          scan_idx_nxt = '0;
          case (stat.in_req)
            REQ_START_VAL: state_nxt = ST_WRITE;
            REQ_SET_FLAT:  state_nxt = ST_FLAT;
            default:       state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_LOAD;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load_sel = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (stat.early) begin
          state_nxt = (stat.req == REQ_QUERY) ? ST_DONE : ST_WRITE;
        end else begin
          cmd.div_init = 1'b1;
          div_cnt_nxt  = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == LAST_DIV) begin
          state_nxt = ST_MUL;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = (stat.req == REQ_QUERY) ? ST_DONE : ST_WRITE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!stat.out_busy) begin
          cmd.push_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd.write_seg = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_FLAT: begin
        cmd.set_flat = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
      div_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      div_cnt_r  <= div_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slr_datapath.sv =====
// Datapath of the scheduled linear ramp: segment ring, scan compare, restoring
// divider, blend multiplier and output register. Depends on slr_pkg.
`default_nettype none

module slr_datapath import slr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [REQ_W-1:0]    in_req,
  input  wire logic [TIME_W-1:0]   in_now_time,
  input  wire logic [VAL_W-1:0]    in_start_value,
  input  wire logic [VAL_W-1:0]    in_end_value,
  input  wire logic [TIME_W-1:0]   in_end_time,
  input  wire dp_cmd_t             cmd,
  output dp_stat_t                 stat,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [VAL_W-1:0]         out_ramp_value,
  output logic                     out_has_value
);

  // captured request
  req_t                     req_r;
  logic [TIME_W-1:0]        now_r, et_in_r;
  logic signed [VAL_W-1:0]  sv_in_r, ev_in_r;

  // segment ring
  logic [TIME_W-1:0]        seg_st_r [NUM_SEG];
  logic [TIME_W-1:0]        seg_et_r [NUM_SEG];
  logic signed [VAL_W-1:0]  seg_sv_r [NUM_SEG];
  logic signed [VAL_W-1:0]  seg_ev_r [NUM_SEG];
  logic [NUM_SEG-1:0]       seg_vld_r;
  logic [SEG_IDX_W-1:0]     wslot_r;

  // scan
  logic                     found_r;
  logic [TIME_W-1:0]        best_r;
  logic [SEG_IDX_W-1:0]     sel_r;
  logic                     hit;

  // selected segment
  logic [TIME_W-1:0]        a_ts_r, a_te_r;
  logic signed [VAL_W-1:0]  a_vs_r, a_ve_r;
  logic                     a_vld_r;

  // evaluation
  logic                     early_r;
  logic [TIME_W-1:0]        num_r, den_r;
  logic signed [VAL_W:0]    diff_r;
  logic [TIME_W:0]          rem2;
  logic [FRAC_W-1:0]        q_r;
  logic signed [FRAC_W+VAL_W+1:0] prod_r;
  logic signed [VAL_W+1:0]  sum;
  logic signed [VAL_W-1:0]  res_r;
  logic [TIME_W-1:0]        rem_r;

  // output register
  logic                     out_vld_r;
  logic [VAL_W-1:0]         out_val_r;
  logic                     out_has_r;

  assign hit = seg_vld_r[cmd.idx] && (seg_st_r[cmd.idx] < now_r) &&
               (!found_r || (seg_st_r[cmd.idx] > best_r));

  assign rem2 = {rem_r, 1'b0};
  assign sum  = {{2{a_vs_r[VAL_W-1]}}, a_vs_r} + prod_r[FRAC_W+VAL_W+1:FRAC_W];

  assign stat.in_req   = req_t'(in_req);
  assign stat.req      = req_r;
  assign stat.early    = early_r;
  assign stat.out_busy = out_vld_r && !out_tready;

  assign out_tvalid     = out_vld_r;
  assign out_ramp_value = out_val_r;
  assign out_has_value  = out_has_r;

  // control state and ring (ring contents are observable after reset)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_vld_r <= '0;
      wslot_r   <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < NUM_SEG; i++) begin
        seg_st_r[i] <= '0;
        seg_et_r[i] <= '0;
        seg_sv_r[i] <= '0;
        seg_ev_r[i] <= '0;
      end
    end else begin
      if (cmd.write_seg) begin
        seg_st_r[wslot_r]  <= now_r;
        seg_et_r[wslot_r]  <= et_in_r;
        seg_sv_r[wslot_r]  <= (req_r == REQ_START_CUR) ? res_r : sv_in_r;
        seg_ev_r[wslot_r]  <= ev_in_r;
        seg_vld_r[wslot_r] <= 1'b1;
        wslot_r <= (wslot_r == SEG_IDX_W'(NUM_SEG - 1)) ? '0 : wslot_r + 1'b1;
      end
      if (cmd.set_flat) begin
        // end times are left as they were
        seg_vld_r <= '1;
        for (int i = 0; i < NUM_SEG; i++) begin
          seg_st_r[i] <= '0;
          seg_sv_r[i] <= sv_in_r;
          seg_ev_r[i] <= sv_in_r;
        end
      end
      if (cmd.push_out) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r   <= req_t'(in_req);
      now_r   <= in_now_time;
      sv_in_r <= in_start_value;
      ev_in_r <= in_end_value;
      et_in_r <= in_end_time;
      found_r <= 1'b0;
      best_r  <= '0;
      sel_r   <= '0;
    end
    if (cmd.scan_step && hit) begin
      found_r <= 1'b1;
      best_r  <= seg_st_r[cmd.idx];
      sel_r   <= cmd.idx;
    end
    if (cmd.load_sel) begin
      a_ts_r  <= seg_st_r[sel_r];
      a_te_r  <= seg_et_r[sel_r];
      a_vs_r  <= seg_sv_r[sel_r];
      a_ve_r  <= seg_ev_r[sel_r];
      a_vld_r <= seg_vld_r[sel_r];
    end
    if (cmd.check) begin
      // at or before start, or invalid: start value; at or after end: end value
      early_r <= !a_vld_r || (now_r <= a_ts_r) || (now_r >= a_te_r);
      res_r   <= (!a_vld_r || (now_r <= a_ts_r)) ? a_vs_r : a_ve_r;
      num_r   <= now_r - a_ts_r;
      den_r   <= a_te_r - a_ts_r;
      diff_r  <= {a_ve_r[VAL_W-1], a_ve_r} - {a_vs_r[VAL_W-1], a_vs_r};
    end
    if (cmd.div_init) begin
      rem_r <= num_r;
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_r <= TIME_W'(rem2 - {1'b0, den_r});
        q_r   <= {q_r[FRAC_W-2:0], 1'b1};
      end else begin
        rem_r <= rem2[TIME_W-1:0];
        q_r   <= {q_r[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, q_r}) * diff_r;
    end
    if (cmd.fin) begin
      res_r <= sum[VAL_W-1:0];
    end
    if (cmd.push_out) begin
      out_val_r <= res_r;
      out_has_r <= a_vld_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scheduled_linear_ramp_core.sv =====
// Scheduled linear ramp: a ring of NUM_SEG ramp segments queried by time.
// Input channel in_*: in_tuser = request kind, in_tdata = times and values.
//   Kinds: start from current value, start with given value, set flat value, query.
// Result channel out_*: one transfer per query, ramp value in out_tdata and the
//   has-value flag in out_tuser. Other requests produce no transfer.
// Sequence: a query scans all NUM_SEG segment registers, then loads and checks
//   the selected segment; when the time falls outside it or it is invalid, the
//   start or end value is taken directly, else the blend divider yields FRAC_W
//   quotient bits at one bit per cycle, followed by a multiply and a sum. A start
//   from the current value takes the same steps, with the segment write in place
//   of the result. A start with a given value or a set-value request is written
//   in the cycle after its transfer. in_tready is high only between requests and
//   returns the cycle after an item completes, so no new request is taken while
//   one is in progress.
// The result sits in an output register, so a new request is taken while it
//   waits; a later query holds in its last step until out_tready frees it.
// Reset (rst_n low, synchronous) clears every segment to zero and invalid,
//   the write slot to 0 and the output register to empty; no warm-up needed.
// Depends on slr_pkg, slr_ctrl, slr_datapath and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module scheduled_linear_ramp_core import slr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [111:0]      in_tdata,  // now_time[31:0], start_value[55:32],
                                            // end_value[79:56], end_time[111:80]
  input  wire logic [REQ_W-1:0]  in_tuser,  // req_type[1:0]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [VAL_W-1:0]       out_tdata, // ramp_value[23:0]
  output logic                   out_tuser  // has_value[0]
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  slr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slr_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req         (in_tuser),
    .in_now_time    (in_tdata[31:0]),
    .in_start_value (in_tdata[55:32]),
    .in_end_value   (in_tdata[79:56]),
    .in_end_time    (in_tdata[111:80]),
    .cmd            (cmd),
    .stat           (stat),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_ramp_value (out_tdata),
    .out_has_value  (out_tuser)
  );

  `AP_NEXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready held after transfer")
  `AP_ALWAYS(a_cmd_excl, clk, rst_n, $onehot0({cmd.load_in, cmd.write_seg, cmd.set_flat, cmd.push_out}), "overlapping commands")
  `AP_IMPLY(a_push_mid_item, clk, rst_n, cmd.push_out || cmd.write_seg, !in_tready, "commit outside an item")
  `AP_NEXT(a_push_shows, clk, rst_n, cmd.push_out, out_tvalid, "pushed result not presented")

endmodule

`default_nettype wire
